FILE: rtl/core/hlcm_pkg.sv
// hlcm_pkg: shared types and constants of the hough line cluster merge block
// controller command and status bundles, field widths, cordic angle table
// no dependencies
package hlcm_pkg;

  localparam int RHO_W    = 16;
  localparam int THETA_W  = 15;
  localparam int MTHETA_W = 17;
  localparam int COUNT_W  = 9;
  localparam int MARGIN_W = 15;

  localparam logic [MARGIN_W-1:0] ANGLE_MARGIN_RST = 15'd910;
  localparam logic [MARGIN_W-1:0] RHO_TOL_RST      = 15'd960;

  // configuration register indexes
  localparam logic REG_ANGLE_MARGIN = 1'b0;
  localparam logic REG_RHO_TOL      = 1'b1;

  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = 4;
  localparam int CORDIC_X0    = 5094007;

  // atan(2^-i) in 2pi/2^32 units
  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41721,     32'd20860
  };

  typedef struct packed {
    logic load_line;
    logic rd_en;
    logic wr_raw0;
    logic wr_conv0;
    logic wr_add;
    logic wr_new;
    logic cvt_start;
    logic line_rot_start;
    logic line_cs_save;
    logic vec_start;
    logic out_load_raw;
    logic out_load_mean;
    logic out_final;
    logic out_overflow;
  } cmd_t;

  typedef struct packed {
    logic cordic_busy;
    logic div_busy;
    logic match;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/core/hlcm_cordic.sv
// hlcm_cordic: shared iterative cordic, rotation (cos/sin) and vectoring (atan2)
// one micro-rotation per cycle, 16 steps
// depends on hlcm_pkg
module hlcm_cordic #(
  parameter int IN_W = 25
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start_rot,
  input  logic                start_vec,
  input  logic [15:0]         rot_angle,
  input  logic signed [IN_W-1:0] vec_x,
  input  logic signed [IN_W-1:0] vec_y,
  output logic                busy,
  output logic signed [15:0]  cos_q,
  output logic signed [15:0]  sin_q,
  output logic signed [16:0]  angle
);
  import hlcm_pkg::*;

  localparam int XW = (IN_W + 3 > 26) ? IN_W + 3 : 26;
  localparam int ZW = 34;
  localparam logic signed [XW-1:0] RND = 128;

  logic signed [XW-1:0] x, y, xs, ys, x_nx, y_nx, vxe, vye;
  logic signed [ZW-1:0] z, z_nx, tab, asum, tsh;
  logic [STEP_W-1:0] step;
  logic vec_mode, flip, zero_in, base, sub;
  logic [15:0] a_tmp, a_adj, u;
  logic signed [15:0] c_raw, s_raw;

  function automatic logic signed [15:0] to_q15(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] r;
    r = (v + RND) >>> 8;
    if (r > 32767) return 16'sd32767;
    if (r < -32767) return -16'sd32767;
    return r[15:0];
  endfunction

  always_comb begin
    a_tmp = rot_angle + 16'h4000;
    a_adj = a_tmp[15] ? (rot_angle ^ 16'h8000) : rot_angle;
    vxe = XW'(vec_x);
    vye = XW'(vec_y);
    xs = x >>> step;
    ys = y >>> step;
    tab = $signed({2'b00, ATAN_TAB[step]});
    sub = vec_mode ? !(!y[XW-1] && (y != '0)) : !z[ZW-1];
    if (sub) begin
      x_nx = x - ys;
      y_nx = y + xs;
      z_nx = z - tab;
    end else begin
      x_nx = x + ys;
      y_nx = y - xs;
      z_nx = z + tab;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start_rot) begin
      busy     <= 1'b1;
      step     <= '0;
      vec_mode <= 1'b0;
      flip     <= a_tmp[15];
      x        <= XW'(CORDIC_X0);
      y        <= '0;
      z        <= $signed({{2{a_adj[15]}}, a_adj, 16'h0000});
    end else if (start_vec) begin
      busy     <= 1'b1;
      step     <= '0;
      vec_mode <= 1'b1;
      base     <= vec_x[IN_W-1];
      zero_in  <= (vec_x == '0) && (vec_y == '0);
      x        <= vec_x[IN_W-1] ? -vxe : vxe;
      y        <= vec_x[IN_W-1] ? -vye : vye;
      z        <= '0;
    end else if (busy) begin
      x    <= x_nx;
      y    <= y_nx;
      z    <= z_nx;
      step <= step + STEP_W'(1);
      if (step == STEP_W'(CORDIC_STEPS - 1)) busy <= 1'b0;
    end
  end

  always_comb begin
    c_raw = to_q15(x);
    s_raw = to_q15(y);
    cos_q = flip ? -c_raw : c_raw;
    sin_q = flip ? -s_raw : s_raw;
    // base half turn plus rounding half up to 2pi/65536
    asum  = z + $signed({2'b00, base, 15'd0, 1'b1, 15'd0});
    tsh   = asum >>> 16;
    u     = tsh[15:0];
    if (zero_in) angle = '0;
    else if (u > 16'd32768) angle = $signed({1'b1, u});
    else angle = $signed({1'b0, u});
  end

endmodule

FILE: rtl/core/hlcm_div.sv
// hlcm_div: iterative unsigned restoring divider, one quotient bit per cycle
// depends on nothing
module hlcm_div #(
  parameter int N_W = 25,
  parameter int D_W = 9
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [N_W-1:0] num,
  input  logic [D_W-1:0] den,
  output logic           busy,
  output logic [N_W-1:0] quot
);
  localparam int CW = $clog2(N_W + 1);

  logic [D_W-1:0] rem, dvs;
  logic [D_W:0]   sh, diff;
  logic [CW-1:0]  cnt;
  logic           ge;

  always_comb begin
    sh   = {rem, quot[N_W-1]};
    ge   = sh >= {1'b0, dvs};
    diff = sh - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      rem  <= '0;
      quot <= num;
      dvs  <= den;
    end else if (busy) begin
      rem  <= ge ? diff[D_W-1:0] : sh[D_W-1:0];
      quot <= {quot[N_W-2:0], ge};
      cnt  <= cnt + CW'(1);
      if (cnt == CW'(N_W - 1)) busy <= 1'b0;
    end
  end

endmodule

FILE: rtl/core/hlcm_datapath.sv
// hlcm_datapath: cluster table memory, line registers, mean/angle units,
// match compare, margin registers and the output register
// depends on hlcm_pkg, hlcm_cordic, hlcm_div
module hlcm_datapath #(
  parameter int MAX_CLUSTERS = 64,
  parameter int MAX_LINES    = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  hlcm_pkg::cmd_t                    cmd,
  input  logic [$clog2(MAX_CLUSTERS)-1:0]   addr,
  output hlcm_pkg::sts_t                    sts,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [hlcm_pkg::MARGIN_W-1:0]     cfg_data,
  input  logic signed [hlcm_pkg::RHO_W-1:0] line_rho,
  input  logic [hlcm_pkg::THETA_W-1:0]      line_theta,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [hlcm_pkg::RHO_W-1:0] mean_rho,
  output logic signed [hlcm_pkg::MTHETA_W-1:0] mean_theta,
  output logic [hlcm_pkg::COUNT_W-1:0]      member_count,
  output logic                              table_overflow,
  output logic                              final_cluster
);
  import hlcm_pkg::*;

  localparam int SUM_W = 17 + $clog2(MAX_LINES);
  localparam int CNT_W = $clog2(MAX_LINES + 1);
  localparam int ENT_W = 3 * SUM_W + CNT_W;

  logic [ENT_W-1:0] mem [MAX_CLUSTERS];
  logic [ENT_W-1:0] rd_q, wdata;
  logic             we;

  logic signed [SUM_W-1:0] rd_rho, rd_cos, rd_sin;
  logic [CNT_W-1:0]        rd_size;

  logic [MARGIN_W-1:0] angle_margin, rho_tol;

  logic signed [RHO_W-1:0] raw_rho;
  logic [THETA_W-1:0]      raw_theta;
  logic [16:0]             nrho;
  logic [15:0]             nang;
  logic signed [15:0]      line_c, line_s;
  logic signed [SUM_W-1:0] cvt_rho;

  logic signed [16:0] rho_abs_in, r0_ext, r0_abs;
  logic [15:0]        rot_angle;
  logic               cordic_busy, div_busy;
  logic signed [15:0] c_q, s_q;
  logic signed [16:0] vang;
  logic [SUM_W-1:0]   quot, dnum;

  logic signed [17:0] dr;
  logic [16:0]        dr_abs;
  logic [14:0]        ad;
  logic [15:0]        ad_fold;

  assign rd_rho  = rd_q[ENT_W-1 -: SUM_W];
  assign rd_cos  = rd_q[ENT_W-SUM_W-1 -: SUM_W];
  assign rd_sin  = rd_q[CNT_W+SUM_W-1 -: SUM_W];
  assign rd_size = rd_q[CNT_W-1:0];

  // margin registers
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_margin <= ANGLE_MARGIN_RST;
      rho_tol      <= RHO_TOL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ANGLE_MARGIN: angle_margin <= cfg_data;
        REG_RHO_TOL:      rho_tol      <= cfg_data;
      endcase
    end
  end

  // incoming line, folded to non-negative rho
  always_comb begin
    rho_abs_in = 17'(line_rho);
    if (line_rho[RHO_W-1]) rho_abs_in = -rho_abs_in;
    r0_ext = 17'($signed(rd_rho[15:0]));
    r0_abs = r0_ext[16] ? -r0_ext : r0_ext;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_line) begin
      raw_rho   <= line_rho;
      raw_theta <= line_theta;
      nrho      <= rho_abs_in;
      nang      <= {line_rho[RHO_W-1], line_theta};
    end
    if (cmd.cvt_start) cvt_rho <= SUM_W'(r0_abs);
    if (cmd.line_cs_save) begin
      line_c <= c_q;
      line_s <= s_q;
    end
  end

  assign rot_angle = cmd.cvt_start ? {rd_rho[15], rd_cos[14:0]} : nang;
  assign dnum = rd_rho + SUM_W'(rd_size >> 1);

  hlcm_cordic #(.IN_W(SUM_W)) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .start_rot (cmd.cvt_start | cmd.line_rot_start),
    .start_vec (cmd.vec_start),
    .rot_angle (rot_angle),
    .vec_x     (rd_cos),
    .vec_y     (rd_sin),
    .busy      (cordic_busy),
    .cos_q     (c_q),
    .sin_q     (s_q),
    .angle     (vang)
  );

  hlcm_div #(.N_W(SUM_W), .D_W(CNT_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.vec_start),
    .num   (dnum),
    .den   (rd_size),
    .busy  (div_busy),
    .quot  (quot)
  );

  // table write
  always_comb begin
    we    = cmd.wr_raw0 | cmd.wr_conv0 | cmd.wr_add | cmd.wr_new;
    wdata = {SUM_W'(nrho), SUM_W'(line_c), SUM_W'(line_s), CNT_W'(1)};
    if (cmd.wr_raw0) begin
      wdata = {SUM_W'(raw_rho), SUM_W'(raw_theta), {SUM_W{1'b0}}, CNT_W'(1)};
    end else if (cmd.wr_conv0) begin
      wdata = {cvt_rho, SUM_W'(c_q), SUM_W'(s_q), CNT_W'(1)};
    end else if (cmd.wr_add) begin
      wdata = {rd_rho + SUM_W'(nrho), rd_cos + SUM_W'(line_c),
               rd_sin + SUM_W'(line_s), rd_size + CNT_W'(1)};
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    if (cmd.rd_en) rd_q <= mem[addr];
  end

  // match against the cluster just evaluated
  always_comb begin
    dr      = $signed({1'b0, quot[16:0]}) - $signed({1'b0, nrho});
    dr_abs  = dr[17] ? 17'(-dr) : dr[16:0];
    ad      = vang[14:0] - nang[14:0];
    ad_fold = (ad > 15'd16384) ? (16'd32768 - 16'(ad)) : 16'(ad);
    sts.match       = (dr_abs < 17'(rho_tol)) && (ad_fold < 16'(angle_margin));
    sts.cordic_busy = cordic_busy;
    sts.div_busy    = div_busy;
    sts.out_free    = !out_valid || out_ready;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load_raw || cmd.out_load_mean) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load_raw) begin
      mean_rho       <= rd_rho[15:0];
      mean_theta     <= MTHETA_W'(rd_cos[14:0]);
      member_count   <= COUNT_W'(1);
      table_overflow <= 1'b0;
      final_cluster  <= 1'b1;
    end else if (cmd.out_load_mean) begin
      mean_rho       <= (quot > SUM_W'(32767)) ? 16'sd32767 : quot[15:0];
      mean_theta     <= vang;
      member_count   <= COUNT_W'(rd_size);
      table_overflow <= cmd.out_overflow;
      final_cluster  <= cmd.out_final;
    end
  end

endmodule

FILE: rtl/core/hlcm_ctrl.sv
// hlcm_ctrl: sequencer for line intake, cluster scan, insertion and set emission
// holds the set counters; drives hlcm_datapath by command bundle
// depends on hlcm_pkg
module hlcm_ctrl #(
  parameter int MAX_CLUSTERS = 64,
  parameter int MAX_LINES    = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            set_end,
  input  hlcm_pkg::sts_t                  sts,
  output hlcm_pkg::cmd_t                  cmd,
  output logic [$clog2(MAX_CLUSTERS)-1:0] addr
);
  import hlcm_pkg::*;

  localparam int AW = $clog2(MAX_CLUSTERS);
  localparam int UW = $clog2(MAX_CLUSTERS + 1);
  localparam int LW = $clog2(MAX_LINES + 1);

  typedef enum logic [14:0] {
    S_IDLE    = 15'b000000000000001,
    S_START   = 15'b000000000000010,
    S_CV_RD   = 15'b000000000000100,
    S_CV_ROT  = 15'b000000000001000,
    S_LN_ROT  = 15'b000000000010000,
    S_SC_RD   = 15'b000000000100000,
    S_SC_GO   = 15'b000000001000000,
    S_SC_WAIT = 15'b000000010000000,
    S_SC_CMP  = 15'b000000100000000,
    S_NEW     = 15'b000001000000000,
    S_END     = 15'b000010000000000,
    S_EM_RAW  = 15'b000100000000000,
    S_EM_RD   = 15'b001000000000000,
    S_EM_GO   = 15'b010000000000000,
    S_EM_WAIT = 15'b100000000000000
  } state_t;

  state_t state, state_next;
  logic [UW-1:0] used, used_next;
  logic [LW-1:0] lines, lines_next;
  logic [AW-1:0] idx, idx_next;
  logic          dropped, dropped_next;
  logic          last;
  logic          last_idx;

  assign in_ready = (state == S_IDLE);
  assign last_idx = (UW'(idx) + UW'(1)) == used;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      used    <= '0;
      lines   <= '0;
      idx     <= '0;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      used    <= used_next;
      lines   <= lines_next;
      idx     <= idx_next;
      dropped <= dropped_next;
    end
    if (in_valid && in_ready) last <= set_end;
  end

  always_comb begin
    state_next   = state;
    used_next    = used;
    lines_next   = lines;
    idx_next     = idx;
    dropped_next = dropped;
    cmd          = '0;
    addr         = '0;
    cmd.load_line    = in_valid && in_ready;
    cmd.out_overflow = dropped;
    cmd.out_final    = last_idx;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_START;
      end
      S_START: begin
        if (lines == '0) begin
          // first line of a set stays raw in entry 0
          cmd.wr_raw0 = 1'b1;
          used_next   = UW'(1);
          lines_next  = LW'(1);
          state_next  = S_END;
        end else if (lines == LW'(1)) begin
          cmd.rd_en  = 1'b1;
          state_next = S_CV_RD;
        end else if (lines >= LW'(MAX_LINES)) begin
          dropped_next = 1'b1;
          state_next   = S_END;
        end else begin
          cmd.line_rot_start = 1'b1;
          state_next         = S_LN_ROT;
        end
      end
      S_CV_RD: begin
        cmd.cvt_start = 1'b1;
        state_next    = S_CV_ROT;
      end
      S_CV_ROT: begin
        if (!sts.cordic_busy) begin
          cmd.wr_conv0       = 1'b1;
          cmd.line_rot_start = 1'b1;
          state_next         = S_LN_ROT;
        end
      end
      S_LN_ROT: begin
        if (!sts.cordic_busy) begin
          cmd.line_cs_save = 1'b1;
          idx_next         = '0;
          state_next       = S_SC_RD;
        end
      end
      S_SC_RD: begin
        addr       = idx;
        cmd.rd_en  = 1'b1;
        state_next = S_SC_GO;
      end
      S_SC_GO: begin
        cmd.vec_start = 1'b1;
        state_next    = S_SC_WAIT;
      end
      S_SC_WAIT: begin
        if (!sts.cordic_busy && !sts.div_busy) state_next = S_SC_CMP;
      end
      S_SC_CMP: begin
        addr = idx;
        if (sts.match) begin
          cmd.wr_add = 1'b1;
          lines_next = lines + LW'(1);
          state_next = S_END;
        end else if (last_idx) begin
          state_next = S_NEW;
        end else begin
          idx_next   = idx + AW'(1);
          state_next = S_SC_RD;
        end
      end
      S_NEW: begin
        addr = used[AW-1:0];
        if (used < UW'(MAX_CLUSTERS)) begin
          cmd.wr_new = 1'b1;
          used_next  = used + UW'(1);
        end else begin
          dropped_next = 1'b1;
        end
        lines_next = lines + LW'(1);
        state_next = S_END;
      end
      S_END: begin
        if (!last) begin
          state_next = S_IDLE;
        end else if (lines == LW'(1)) begin
          cmd.rd_en  = 1'b1;
          state_next = S_EM_RAW;
        end else begin
          idx_next   = '0;
          state_next = S_EM_RD;
        end
      end
      S_EM_RAW: begin
        if (sts.out_free) begin
          cmd.out_load_raw = 1'b1;
          used_next        = '0;
          lines_next       = '0;
          dropped_next     = 1'b0;
          state_next       = S_IDLE;
        end
      end
      S_EM_RD: begin
        addr       = idx;
        cmd.rd_en  = 1'b1;
        state_next = S_EM_GO;
      end
      S_EM_GO: begin
        cmd.vec_start = 1'b1;
        state_next    = S_EM_WAIT;
      end
      S_EM_WAIT: begin
        if (!sts.cordic_busy && !sts.div_busy && sts.out_free) begin
          cmd.out_load_mean = 1'b1;
          if (last_idx) begin
            used_next    = '0;
            lines_next   = '0;
            dropped_next = 1'b0;
            state_next   = S_IDLE;
          end else begin
            idx_next   = idx + AW'(1);
            state_next = S_EM_RD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: rtl/core/hough_line_cluster_merge_top.sv
// hough_line_cluster_merge_top: leader clustering of hough lines, top level
// joins hlcm_ctrl (sequencer) and hlcm_datapath (table, cordic, divider)
// depends on hlcm_pkg, hlcm_ctrl, hlcm_datapath
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+-------------------------------------
//   in       | input     | in_valid / in_ready  | line_rho, line_theta, set_end
//   out      | output    | out_valid / out_ready| mean_rho, mean_theta, member_count,
//            |           |                      | table_overflow, final_cluster
//   cfg      | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one line is worked at a time; in_ready is high only while the sequencer is idle.
// a line is taken in and its own cos/sin is found by cordic rotation; it is then
// checked against the stored clusters in turn until one matches, the bit-serial mean
// divider running beside the atan2 cordic for each, and opens a new cluster if none
// matches. the first line of a set is stored raw; the second first converts that
// line to cluster form. the last line of a set then emits every cluster's mean.
// reset is synchronous; no clearing pass of the table. reset clears the set counters
// and sequencer state, clears out_valid and reloads the margin reset values.
// a stalled output holds the final beat in the output register while the next
// line is taken in; emission of further clusters waits on out_ready.
module hough_line_cluster_merge_top #(
  parameter int MAX_CLUSTERS = 64,
  parameter int MAX_LINES    = 256
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [hlcm_pkg::RHO_W-1:0]     line_rho,
  input  logic [hlcm_pkg::THETA_W-1:0]          line_theta,
  input  logic                                  set_end,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [hlcm_pkg::RHO_W-1:0]     mean_rho,
  output logic signed [hlcm_pkg::MTHETA_W-1:0]  mean_theta,
  output logic [hlcm_pkg::COUNT_W-1:0]          member_count,
  output logic                                  table_overflow,
  output logic                                  final_cluster,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic                                  cfg_index,
  input  logic [hlcm_pkg::MARGIN_W-1:0]         cfg_data
);
  import hlcm_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic [$clog2(MAX_CLUSTERS)-1:0] addr;

  // margin writes go straight into the margin registers, so the config port never stalls
  assign cfg_ready = 1'b1;

  hlcm_ctrl #(
    .MAX_CLUSTERS (MAX_CLUSTERS),
    .MAX_LINES    (MAX_LINES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .set_end  (set_end),
    .sts      (sts),
    .cmd      (cmd),
    .addr     (addr)
  );

  hlcm_datapath #(
    .MAX_CLUSTERS (MAX_CLUSTERS),
    .MAX_LINES    (MAX_LINES)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .addr           (addr),
    .sts            (sts),
    .cfg_we         (cfg_valid & cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .line_rho       (line_rho),
    .line_theta     (line_theta),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .mean_rho       (mean_rho),
    .mean_theta     (mean_theta),
    .member_count   (member_count),
    .table_overflow (table_overflow),
    .final_cluster  (final_cluster)
  );

endmodule

FILE: bench/tb_hough_line_cluster_merge_top.sv
// testbench for hough_line_cluster_merge_top: line sets in, cluster means out
// depends on hlcm_pkg and the block rtl; predicts every cluster beat locally
`timescale 1ns / 100ps

module tb_hough_line_cluster_merge_top;
  import hlcm_pkg::*;

  localparam int TABLE_DEPTH  = 64;
  localparam int LINE_LIMIT   = 256;
  localparam int DRAIN_CYCLES = 3000;     // one line against a full table, with room to spare
  localparam int CYCLE_LIMIT  = 8000000;
  localparam int RANDOM_ITEMS = 32;

  typedef struct {
    logic signed [RHO_W-1:0] rho;
    logic [THETA_W-1:0]      theta;
    logic                    last;
  } line_t;

  typedef struct {
    logic signed [RHO_W-1:0]    rho;
    logic signed [MTHETA_W-1:0] theta;
    logic [COUNT_W-1:0]         count;
    logic                       ovf;
    logic                       fin;
  } cluster_beat_t;

  logic clk, rst;
  logic in_valid, in_ready, set_end;
  logic signed [RHO_W-1:0] line_rho;
  logic [THETA_W-1:0] line_theta;
  logic out_valid, out_ready;
  logic signed [RHO_W-1:0] mean_rho;
  logic signed [MTHETA_W-1:0] mean_theta;
  logic [COUNT_W-1:0] member_count;
  logic table_overflow, final_cluster;
  logic cfg_valid, cfg_ready, cfg_index;
  logic [MARGIN_W-1:0] cfg_data;

  hough_line_cluster_merge_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .line_rho(line_rho), .line_theta(line_theta), .set_end(set_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .mean_rho(mean_rho), .mean_theta(mean_theta), .member_count(member_count),
    .table_overflow(table_overflow), .final_cluster(final_cluster),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // lines waiting to be sent, cluster beats still owed by the block
  line_t         line_queue[$];
  cluster_beat_t cluster_queue[$];

  // model copy of the margins and the cluster table
  int unsigned ang_margin, rho_tol;
  int          tab_rho[TABLE_DEPTH];
  int          tab_cos[TABLE_DEPTH];
  int          tab_sin[TABLE_DEPTH];
  int unsigned tab_size[TABLE_DEPTH];
  int unsigned used_clusters, set_lines;
  bit          set_dropped;

  int  error_count, lines_sent, beats_seen, sets_closed, cycle_count;
  bit  calm;            // no idling on either side while set

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  // round a q.23 cordic value to q1.15, clamped to +-32767
  function automatic int to_q15(longint v);
    longint r;
    r = (v + 128) >>> 8;
    if (r > 32767) r = 32767;
    if (r < -32767) r = -32767;
    return int'(r);
  endfunction

  // cos and sin of a 16-bit angle by rotation cordic, folded to the right half plane
  task automatic unit_vector(input int unsigned a, output int c, output int s);
    longint z, px, py, dx, dy;
    bit flip;
    int unsigned aa;
    aa = a & 32'hFFFF;
    flip = ((aa + 16384) & 32'h8000) != 0;
    if (flip) aa = aa ^ 32'h8000;
    z = (aa >= 32768 ? longint'(aa) - 65536 : longint'(aa)) * 65536;
    px = longint'(CORDIC_X0);
    py = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = py >>> i;
      dy = px >>> i;
      if (z >= 0) begin
        px -= dx; py += dy; z -= longint'(ATAN_TAB[i]);
      end else begin
        px += dx; py -= dy; z += longint'(ATAN_TAB[i]);
      end
    end
    c = to_q15(px);
    s = to_q15(py);
    if (flip) begin
      c = -c; s = -s;
    end
  endtask

  // atan2 of the summed vector by vectoring cordic, wrapped to -32767..32768
  function automatic int vector_angle(longint cx, longint sy);
    longint base, z, nx, ny, t;
    int unsigned u;
    base = 0;
    z = 0;
    if (cx == 0 && sy == 0) return 0;
    if (cx < 0) begin
      cx = -cx; sy = -sy; base = 64'sd2147483648;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (sy > 0) begin
        nx = cx + (sy >>> i); ny = sy - (cx >>> i); z += longint'(ATAN_TAB[i]);
      end else begin
        nx = cx - (sy >>> i); ny = sy + (cx >>> i); z -= longint'(ATAN_TAB[i]);
      end
      cx = nx; sy = ny;
    end
    t = (base + z + 32768) >>> 16;
    u = int'(t) & 32'hFFFF;
    return u > 32768 ? int'(u) - 65536 : int'(u);
  endfunction

  function automatic int cluster_mean_rho(int j);
    int unsigned n, acc;
    n = tab_size[j] != 0 ? tab_size[j] : 1;
    acc = ($unsigned(tab_rho[j]) + n / 2) / n;
    return int'(acc);
  endfunction

  task automatic accumulate(int j, int r, int unsigned ang, bit fresh);
    int c, s;
    unit_vector(ang, c, s);
    if (fresh) begin
      tab_rho[j] = 0; tab_cos[j] = 0; tab_sin[j] = 0; tab_size[j] = 0;
    end
    tab_rho[j] += r;
    tab_cos[j] += c;
    tab_sin[j] += s;
    tab_size[j] += 1;
  endtask

  // negative rho flips to positive with a half turn added
  task automatic flip_negative(inout int r, inout int unsigned ang);
    if (r < 0) begin
      r = -r;
      ang = (ang + 32768) & 32'hFFFF;
    end
  endtask

  // leader clustering: first matching cluster wins, else a new one if room
  task automatic merge_line(int r, int unsigned ang);
    int dr;
    int unsigned d;
    for (int j = 0; j < used_clusters; j++) begin
      dr = cluster_mean_rho(j) - r;
      d = ($unsigned(vector_angle(tab_cos[j], tab_sin[j])) - ang) & 32'h7FFF;
      if (dr < 0) dr = -dr;
      if (d > 16384) d = 32768 - d;
      if ($unsigned(dr) < rho_tol && d < ang_margin) begin
        accumulate(j, r, ang, 1'b0);
        return;
      end
    end
    if (used_clusters < TABLE_DEPTH) begin
      accumulate(used_clusters, r, ang, 1'b1);
      used_clusters++;
    end else begin
      set_dropped = 1'b1;
    end
  endtask

  task automatic predict_clusters(line_t ln);
    int r, r0, m;
    int unsigned ang, a0;
    cluster_beat_t b;
    r = int'(ln.rho);
    ang = 32'(ln.theta);
    if (set_lines == 0) begin
      // first line kept raw so a lone line can pass through untouched
      tab_rho[0] = r; tab_cos[0] = int'(ang); tab_sin[0] = 0; tab_size[0] = 1;
      used_clusters = 1;
      set_lines = 1;
    end else begin
      if (set_lines == 1) begin
        r0 = tab_rho[0];
        a0 = $unsigned(tab_cos[0]) & 32'h7FFF;
        flip_negative(r0, a0);
        accumulate(0, r0, a0, 1'b1);
      end
      if (set_lines >= LINE_LIMIT) begin
        set_dropped = 1'b1;
      end else begin
        flip_negative(r, ang);
        merge_line(r, ang);
        set_lines++;
      end
    end
    if (!ln.last) return;
    sets_closed++;
    if (set_lines == 1) begin
      b.rho = RHO_W'(tab_rho[0]);
      b.theta = MTHETA_W'(tab_cos[0]);
      b.count = COUNT_W'(1);
      b.ovf = 1'b0;
      b.fin = 1'b1;
      cluster_queue.insert(cluster_queue.size(), b);
    end else begin
      for (int k = 0; k < used_clusters; k++) begin
        m = cluster_mean_rho(k);
        if (m > 32767) m = 32767;   // mean of 32768 saturates
        b.rho = RHO_W'(m);
        b.theta = MTHETA_W'(vector_angle(tab_cos[k], tab_sin[k]));
        b.count = COUNT_W'(tab_size[k]);
        b.ovf = set_dropped;
        b.fin = (k + 1 == used_clusters);
        cluster_queue.insert(cluster_queue.size(), b);
      end
    end
    used_clusters = 0;
    set_lines = 0;
    set_dropped = 0;
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    bit nv;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      nv = in_valid;
      if (in_valid && in_ready) begin
        predict_clusters(line_queue.pop_front());
        lines_sent++;
        nv = 1'b0;
      end
      if (!nv && line_queue.size() > 0 && (calm || $urandom_range(99) >= 37)) begin
        line_rho   <= line_queue[0].rho;
        line_theta <= line_queue[0].theta;
        set_end    <= line_queue[0].last;
        nv = 1'b1;
      end
      in_valid <= nv;
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic report(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    cluster_beat_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        beats_seen++;
        if (cluster_queue.size() == 0) begin
          report("unexpected beat, mean_rho", mean_rho, 0);
        end else begin
          e = cluster_queue.pop_front();
          if (mean_rho !== e.rho) report("mean_rho", mean_rho, e.rho);
          if (mean_theta !== e.theta) report("mean_theta", mean_theta, e.theta);
          if (member_count !== e.count) report("member_count", member_count, e.count);
          if (table_overflow !== e.ovf) report("table_overflow", table_overflow, e.ovf);
          if (final_cluster !== e.fin) report("final_cluster", final_cluster, e.fin);
        end
      end
      out_ready <= calm || $urandom_range(99) >= 37;
    end
  end

  // hard stop if the block hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic push_line(int r, int unsigned th, bit last);
    line_t ln;
    ln.rho = RHO_W'(r);
    ln.theta = THETA_W'(th);
    ln.last = last;
    line_queue.insert(line_queue.size(), ln);
  endtask

  // write one margin register, model copy follows at the handshake
  task automatic write_margin(logic idx, int unsigned val);
    cfg_index <= idx;
    cfg_data  <= MARGIN_W'(val);
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    if (idx == REG_ANGLE_MARGIN) ang_margin = val & 32'h7FFF;
    else rho_tol = val & 32'h7FFF;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // let every queued line go in and every beat come out, then let the block settle
  task automatic drain;
    do @(posedge clk); while (line_queue.size() != 0 || in_valid || cluster_queue.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_margins(int unsigned am, int unsigned rm);
    drain();
    write_margin(REG_ANGLE_MARGIN, am);
    write_margin(REG_RHO_TOL, rm);
  endtask

  // a set of lines scattered around a few centers, some pure noise
  task automatic random_set(inout int budget);
    int n, ncen, k, r, jr, jt;
    int cr[3];
    int unsigned ct[3];
    n = $urandom_range(99) < 85 ? $urandom_range(1, 6) : $urandom_range(7, 20);
    ncen = $urandom_range(1, 3);
    for (int c = 0; c < ncen; c++) begin
      cr[c] = $urandom_range(0, 20000);
      ct[c] = $urandom_range(0, 32767);
    end
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 15) begin
        push_line(int'($urandom_range(0, 65535)) - 32768, $urandom_range(0, 32767), i == n - 1);
      end else begin
        k = $urandom_range(0, ncen - 1);
        jr = int'($urandom_range(0, 2400)) - 1200;
        jt = int'($urandom_range(0, 2000)) - 1000;
        r = cr[k] + jr;
        if ($urandom_range(1)) r = -r;
        push_line(r, (ct[k] + jt) & 32'h7FFF, i == n - 1);
      end
    end
    budget -= n;
  endtask

  task automatic random_phase(int lines);
    while (lines > 0) random_set(lines);
  endtask

  initial begin
    in_valid <= 1'b0; line_rho <= '0; line_theta <= '0; set_end <= 1'b0;
    out_ready <= 1'b0; cfg_valid <= 1'b0; cfg_index <= REG_ANGLE_MARGIN; cfg_data <= '0;
    rst <= 1'b1;
    calm = 1'b0;
    ang_margin = ANGLE_MARGIN_RST;
    rho_tol = RHO_TOL_RST;
    used_clusters = 0; set_lines = 0; set_dropped = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // lone lines pass through raw, including the field extremes
    push_line(-5, 100, 1);
    push_line(-32768, 32767, 1);
    push_line(32767, 0, 1);
    // a small set: a negative rho line folds onto the first cluster
    push_line(100, 200, 0);
    push_line(-110, 210, 0);
    push_line(5000, 16000, 0);
    push_line(32767, 32767, 0);
    push_line(0, 0, 1);

    // widest margins: almost every line merges; mean of 32768 saturates
    set_margins(16384, 32767);
    push_line(-32768, 0, 0);
    push_line(-32768, 0, 1);
    // more lines than one set may hold: the tail is dropped;
    // a long run with no idling on either side
    calm = 1'b1;
    for (int i = 0; i < LINE_LIMIT + 1; i++)
      push_line(int'($urandom_range(0, 65535)) - 32768, $urandom_range(0, 32767),
                i == LINE_LIMIT);

    // zero margins: nothing matches, the table fills and overflows
    set_margins(0, 0);
    calm = 1'b0;
    for (int i = 0; i < TABLE_DEPTH + 2; i++)
      push_line(i * 300, (i * 997) & 32'h7FFF, i == TABLE_DEPTH + 1);

    // random sets under two margin settings: the reset values, then a random pair
    set_margins(910, 960);
    random_phase(RANDOM_ITEMS / 2);
    set_margins($urandom_range(0, 16384), $urandom_range(0, 32767));
    random_phase(RANDOM_ITEMS / 2);
    drain();

    $display("covered %0d lines in %0d sets, %0d cluster beats checked",
             lines_sent, sets_closed, beats_seen);
    $display("margins swept from zero to full scale, overflow and raw single-line sets hit");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: hough_line_cluster_merge_top.f
rtl/core/hlcm_pkg.sv
rtl/core/hlcm_cordic.sv
rtl/core/hlcm_div.sv
rtl/core/hlcm_datapath.sv
rtl/core/hlcm_ctrl.sv
rtl/core/hough_line_cluster_merge_top.sv
bench/tb_hough_line_cluster_merge_top.sv
